// ===== src/tlb_pkg.sv =====
// ============================================================================
// tlb_pkg
// Shared constants, codes and the structures that travel along the cell row
// of the fully associative translation buffer.
// ============================================================================
package tlb_pkg;

    // Geometry of the buffer and widths of the stored fields.
    localparam int DEPTH     = 32;
    localparam int PAGE_BITS = 20;
    localparam int PID_W     = 32;
    localparam int TIME_W    = 32;
    localparam int FRAME_W   = PAGE_BITS;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SLOT_W    = 5;
    localparam int LIMIT_W   = 6;

    // Stream payload layout.
    localparam int PID_LSB   = 0;
    localparam int PAGE_LSB  = PID_W;
    localparam int FRAME_LSB = PID_W + PAGE_BITS;
    localparam int S_TDATA_W = ((PID_W + 2 * PAGE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FRAME_W + SLOT_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LIMIT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = LIMIT_W'(32);

    // Replacement policies and commands.
    localparam logic POL_FIFO   = 1'b0;
    localparam logic POL_LRU    = 1'b1;
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Search token that walks down the row, one cell per cycle.
    typedef struct packed {
        logic                 valid;
        logic [PID_W-1:0]     pid;
        logic [PAGE_BITS-1:0] page;
        logic                 found;
        logic [IDX_W-1:0]     match_idx;
        logic [FRAME_W-1:0]   match_frame;
        logic                 has_best;
        logic [TIME_W-1:0]    best_time;
        logic [IDX_W-1:0]     best_idx;
    } t_scan;

    // Entry update broadcast to every cell; only the addressed cell takes it.
    typedef struct packed {
        logic                 we_all;
        logic                 we_use;
        logic [IDX_W-1:0]     slot;
        logic [PID_W-1:0]     pid;
        logic [PAGE_BITS-1:0] page;
        logic [FRAME_W-1:0]   frame;
        logic [TIME_W-1:0]    stamp;
    } t_wr;

endpackage

// ===== src/tlb_fifo_lru_replacement.sv =====
// ============================================================================
// tlb_fifo_lru_replacement
// Fully associative translation buffer with FIFO or LRU replacement.
// ============================================================================
// Usage:
//   Requests arrive on the slave stream: tuser carries the command (lookup or
//   insert), tdata the process id, page number and frame to store. Each
//   request yields exactly one transfer on the master stream: tuser is the
//   hit flag, tdata the frame and the slot that hit or was written.
//   The configuration channel sets the policy (index 0) and the number of
//   entries in use (index 1); write it only while no request is in flight.
//   One request is handled at a time. A request is registered, walks the row
//   of DEPTH entry cells, one cell per clock, is captured from the last cell
//   and is then committed to the output register; the next request is taken
//   once the block is idle again. The result sits in an output register; if
//   the receiver stalls, a new request is still accepted and walked, and it
//   waits before its commit until the previous result has been taken.
//   Reset empties the buffer, clears the time counter and selects FIFO with
//   all 32 entries in use. No clearing pass is needed.
// ============================================================================
module tlb_fifo_lru_replacement (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Requests.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [tlb_pkg::S_TDATA_W-1:0]   i_s_tdata,  // process_id, page_number, frame_number
    input  logic                            i_s_tuser,  // command
    // Results.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [tlb_pkg::M_TDATA_W-1:0]   o_m_tdata,  // frame_out, slot
    output logic                            o_m_tuser,  // hit
    // Configuration writes.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tlb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tlb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tlb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state               r_state;
    logic                 r_policy;
    logic [LIMIT_W-1:0]   r_limit;
    logic [CNT_W-1:0]     r_fill;
    logic [TIME_W-1:0]    r_time;
    logic                 r_cmd;
    logic [FRAME_W-1:0]   r_frame;
    t_scan                r_req;
    t_scan                r_res;
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [FRAME_W-1:0]   r_out_frame;
    logic [SLOT_W-1:0]    r_out_slot;

    t_scan                w_tail;
    t_wr                  w_wr;
    logic [CNT_W-1:0]     w_lim_eff;
    logic                 w_room;
    logic [IDX_W-1:0]     w_ins_slot;
    logic                 w_commit;
    logic                 w_is_insert;
    logic                 w_refresh;

    // Effective number of entries: zero acts as one, anything above DEPTH
    // acts as DEPTH.
    always_comb begin
        if (r_limit == '0) begin
            w_lim_eff = CNT_W'(1);
        end else if ({1'b0, r_limit} > (LIMIT_W + 1)'(DEPTH)) begin
            w_lim_eff = CNT_W'(DEPTH);
        end else begin
            w_lim_eff = CNT_W'(r_limit);
        end
    end

    // Commit decision and the entry update that goes to the row.
    always_comb begin
        w_is_insert = (r_cmd == CMD_INSERT);
        w_commit    = (r_state == S_COMMIT) && (!r_out_valid || i_m_tready);
        w_room      = r_fill < w_lim_eff;
        w_ins_slot  = w_room ? r_fill[IDX_W-1:0] : r_res.best_idx;
        w_refresh   = !w_is_insert && r_res.found && (r_policy == POL_LRU);
        w_wr.we_all = w_commit && w_is_insert;
        w_wr.we_use = w_commit && w_refresh;
        w_wr.slot   = w_is_insert ? w_ins_slot : r_res.match_idx;
        w_wr.pid    = r_res.pid;
        w_wr.page   = r_res.page;
        w_wr.frame  = r_frame;
        w_wr.stamp  = r_time;
    end

    tlb_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fill_count (r_fill),
        .i_policy     (r_policy),
        .i_wr         (w_wr),
        .i_scan       (r_req),
        .o_scan       (w_tail)
    );

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req.valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_policy    <= POL_FIFO;
            r_limit     <= LIMIT_RESET;
            r_fill      <= '0;
            r_time      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_POLICY: begin
                        r_policy <= i_cfg_data[0];
                    end
                    CFG_LIMIT: begin
                        r_limit <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            // A commit refills the output register; otherwise a taken result
            // empties it.
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            r_req.valid <= (r_state == S_IDLE) && i_s_tvalid;

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_req.pid         <= i_s_tdata[PID_LSB +: PID_W];
                        r_req.page        <= i_s_tdata[PAGE_LSB +: PAGE_BITS];
                        r_req.found       <= 1'b0;
                        r_req.match_idx   <= '0;
                        r_req.match_frame <= '0;
                        r_req.has_best    <= 1'b0;
                        r_req.best_time   <= '0;
                        r_req.best_idx    <= '0;
                        r_cmd             <= i_s_tuser;
                        r_frame           <= i_s_tdata[FRAME_LSB +: FRAME_W];
                        r_state           <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_tail.valid) begin
                        r_res   <= w_tail;
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (w_commit) begin
                        if (w_is_insert) begin
                            r_out_hit   <= 1'b1;
                            r_out_frame <= r_frame;
                            r_out_slot  <= SLOT_W'(w_ins_slot);
                            r_time      <= r_time + TIME_W'(1);
                            if (w_room) begin
                                r_fill <= r_fill + CNT_W'(1);
                            end
                        end else if (r_res.found) begin
                            r_out_hit   <= 1'b1;
                            r_out_frame <= r_res.match_frame;
                            r_out_slot  <= SLOT_W'(r_res.match_idx);
                            if (w_refresh) begin
                                r_time <= r_time + TIME_W'(1);
                            end
                        end else begin
                            r_out_hit   <= 1'b0;
                            r_out_frame <= '0;
                            r_out_slot  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tuser   = r_out_hit;
    assign o_m_tdata   = M_TDATA_W'({r_out_slot, r_out_frame});

endmodule

// ===== src/tlb_cell.sv =====
// ============================================================================
// tlb_cell
// One entry of the buffer. Compares the passing search token against its key,
// folds its age into the oldest-entry search and hands the token on.
// ============================================================================
module tlb_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tlb_pkg::IDX_W-1:0]  i_index,
    input  logic [tlb_pkg::CNT_W-1:0]  i_fill_count,
    input  logic                       i_policy,
    input  tlb_pkg::t_wr               i_wr,
    input  tlb_pkg::t_scan             i_scan,
    output tlb_pkg::t_scan             o_scan
);
    import tlb_pkg::*;

    logic [PID_W-1:0]     r_pid;
    logic [PAGE_BITS-1:0] r_page;
    logic [FRAME_W-1:0]   r_frame;
    logic [TIME_W-1:0]    r_birth;
    logic [TIME_W-1:0]    r_use;
    t_scan                r_scan;
    t_scan                n_scan;
    logic                 w_filled;
    logic                 w_hit;
    logic [TIME_W-1:0]    w_age;

    // Only filled entries take part; the first match along the row wins and
    // a strictly smaller age is needed to displace an earlier candidate.
    always_comb begin
        w_filled = CNT_W'(i_index) < i_fill_count;
        w_hit    = w_filled && (r_pid == i_scan.pid) && (r_page == i_scan.page);
        w_age    = (i_policy == POL_LRU) ? r_use : r_birth;
        n_scan   = i_scan;
        if (w_hit && !i_scan.found) begin
            n_scan.found       = 1'b1;
            n_scan.match_idx   = i_index;
            n_scan.match_frame = r_frame;
        end
        if (w_filled && (!i_scan.has_best || (w_age < i_scan.best_time))) begin
            n_scan.has_best  = 1'b1;
            n_scan.best_time = w_age;
            n_scan.best_idx  = i_index;
        end
    end

    // Token register towards the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.valid <= 1'b0;
        end else begin
            r_scan <= n_scan;
        end
    end

    // Entry storage, written only when this cell is addressed.
    always_ff @(posedge i_clk) begin
        if (i_wr.slot == i_index) begin
            if (i_wr.we_all) begin
                r_pid   <= i_wr.pid;
                r_page  <= i_wr.page;
                r_frame <= i_wr.frame;
                r_birth <= i_wr.stamp;
                r_use   <= i_wr.stamp;
            end else if (i_wr.we_use) begin
                r_use   <= i_wr.stamp;
            end
        end
    end

    assign o_scan = r_scan;

endmodule

// ===== src/tlb_chain.sv =====
// ============================================================================
// tlb_chain
// The row of entry cells. The search token enters at cell zero and passes
// through the token register of every cell before it leaves the last one.
// ============================================================================
module tlb_chain (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tlb_pkg::CNT_W-1:0]  i_fill_count,
    input  logic                       i_policy,
    input  tlb_pkg::t_wr               i_wr,
    input  tlb_pkg::t_scan             i_scan,
    output tlb_pkg::t_scan             o_scan
);
    import tlb_pkg::*;

    t_scan w_link [DEPTH+1];

    assign w_link[0] = i_scan;

    // One cell per entry, each fed by its left-hand neighbour.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        tlb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (IDX_W'(k)),
            .i_fill_count (i_fill_count),
            .i_policy     (i_policy),
            .i_wr         (i_wr),
            .i_scan       (w_link[k]),
            .o_scan       (w_link[k+1])
        );
    end

    assign o_scan = w_link[DEPTH];

endmodule

// ===== src/tlb_chk.sv =====
// ============================================================================
// tlb_chk
// Port-level checks of the translation buffer, attached by a bind statement.
// ============================================================================
module tlb_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [tlb_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input logic                            o_m_tuser
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending after reset");

    // A miss reports frame zero in slot zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("miss with non-zero payload");

    // Only one request is in flight: a transfer closes the request channel.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second request taken while one is in flight");

endmodule

bind tlb_fifo_lru_replacement tlb_chk u_tlb_chk (.*);

// ===== tb/tb_tlb_fifo_lru_replacement.sv =====
// ============================================================================
// tb_tlb_fifo_lru_replacement
// Self-checking bench for the fully associative translation buffer.
// ============================================================================
// A mirror of the buffer, with its own entries, fill count and time stamps,
// predicts the result of every accepted request. Accepted results are
// checked field by field, in order, against those predictions. A short
// directed run covers empty lookups, field extremes, near misses, duplicate
// keys and both replacement policies. Random phases then switch the policy
// and the entry limit, including the out-of-range limits and a limit lowered
// below the fill count. Both streams idle at random, and the result side
// holds off once for a long stretch so that the block stalls its input.
// ============================================================================
module tb_tlb_fifo_lru_replacement;

    timeunit 1ns;
    timeprecision 1ps;

    import tlb_pkg::*;

    // One translation result as it leaves the block.
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [SLOT_W-1:0]  slot;
    } t_tlb_result;

    // A lookup key kept so that random lookups find real entries.
    typedef struct packed {
        logic [PID_W-1:0]     pid;
        logic [PAGE_BITS-1:0] page;
    } t_tlb_key;

    // ------------------------------------------------------------------------
    // Mirror of the buffer: predicts translations and checks the results.
    // ------------------------------------------------------------------------
    class tlb_mirror;
        logic [PID_W-1:0]     pid_tab[DEPTH];
        logic [PAGE_BITS-1:0] page_tab[DEPTH];
        logic [FRAME_W-1:0]   frame_tab[DEPTH];
        logic [TIME_W-1:0]    born_at[DEPTH];
        logic [TIME_W-1:0]    used_at[DEPTH];
        int unsigned          filled;
        logic [TIME_W-1:0]    clock_now;
        logic                 policy;
        logic [LIMIT_W-1:0]   limit;
        t_tlb_result          awaited[$];
        int unsigned          errors;

        function new();
            filled    = 0;
            clock_now = '0;
            policy    = POL_FIFO;
            limit     = LIMIT_RESET;
            errors    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_POLICY) begin
                policy = value[0];
            end else begin
                limit = value[LIMIT_W-1:0];
            end
        endfunction

        // A zero limit behaves as one entry, anything above the depth as all.
        function int unsigned slots_allowed();
            int unsigned lim;
            lim = limit;
            if (lim < 1) begin
                lim = 1;
            end
            if (lim > DEPTH) begin
                lim = DEPTH;
            end
            return lim;
        endfunction

        // Oldest filled entry by birth or last use; ties go to the lowest index.
        function int unsigned oldest_slot();
            int unsigned pick;
            pick = 0;
            for (int unsigned i = 1; i < filled; i++) begin
                if (policy == POL_LRU) begin
                    if (used_at[i] < used_at[pick]) begin
                        pick = i;
                    end
                end else if (born_at[i] < born_at[pick]) begin
                    pick = i;
                end
            end
            return pick;
        endfunction

        // Called for every accepted request, in acceptance order.
        function void note_request(logic cmd, logic [PID_W-1:0] pid,
                                   logic [PAGE_BITS-1:0] page,
                                   logic [FRAME_W-1:0] frame);
            t_tlb_result res;
            int unsigned s;
            bit          found;
            res   = '0;
            s     = 0;
            found = 1'b0;
            if (cmd == CMD_LOOKUP) begin
                for (int unsigned i = 0; i < filled && !found; i++) begin
                    if (pid_tab[i] == pid && page_tab[i] == page) begin
                        found = 1'b1;
                        s     = i;
                    end
                end
                if (found) begin
                    if (policy == POL_LRU) begin
                        used_at[s] = clock_now;
                        clock_now  = clock_now + 1'b1;
                    end
                    res.hit   = 1'b1;
                    res.frame = frame_tab[s];
                    res.slot  = s[SLOT_W-1:0];
                end
            end else begin
                if (filled < slots_allowed()) begin
                    s      = filled;
                    filled = filled + 1;
                end else begin
                    s = oldest_slot();
                end
                pid_tab[s]   = pid;
                page_tab[s]  = page;
                frame_tab[s] = frame;
                born_at[s]   = clock_now;
                used_at[s]   = clock_now;
                clock_now    = clock_now + 1'b1;
                res.hit      = 1'b1;
                res.frame    = frame;
                res.slot     = s[SLOT_W-1:0];
            end
            awaited.push_back(res);
        endfunction

        // Called for every accepted result.
        function void check_result(logic hit, logic [FRAME_W-1:0] frame,
                                   logic [SLOT_W-1:0] slot);
            t_tlb_result want;
            if (awaited.size() == 0) begin
                $error("result transfer with no request outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, hit);
                errors++;
            end
            if (frame !== want.frame) begin
                $error("frame_out: expected 0x%05h, got 0x%05h", want.frame, frame);
                errors++;
            end
            if (slot !== want.slot) begin
                $error("slot: expected %0d, got %0d", want.slot, slot);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block and shared state.
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    hold_results = 1'b0;
    tlb_mirror             mirror = new();
    t_tlb_key              key_pool[$];

    always #2 clk = ~clk;

    tlb_fifo_lru_replacement u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Driving tasks. Inputs move at the falling edge, handshakes are sampled
    // at the rising edge.
    // ------------------------------------------------------------------------

    // Mostly back to back, sometimes a few cycles, now and then a long gap.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(logic cmd, logic [PID_W-1:0] pid,
                                logic [PAGE_BITS-1:0] page, logic [FRAME_W-1:0] frame);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = '0;
        s_tdata[PAGE_LSB-1:PID_LSB]              = pid;
        s_tdata[FRAME_LSB-1:PAGE_LSB]            = page;
        s_tdata[FRAME_LSB+FRAME_W-1:FRAME_LSB]   = frame;
        do @(posedge clk); while (!s_tready);
        mirror.note_request(cmd, pid, page, frame);
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Let every result arrive, then give the block time to settle.
    task automatic wait_quiet();
        while (mirror.outstanding() != 0) @(posedge clk);
        repeat (DEPTH + 5) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        mirror.write_register(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Upper bits of the policy word are ignored by the block; keep them random.
    task automatic configure(logic pol, logic [CFG_DATA_W-1:0] lim);
        logic [CFG_DATA_W-1:0] word;
        @(negedge clk);
        s_tvalid = 1'b0;
        wait_quiet();
        word    = CFG_DATA_W'($urandom_range(0, 63));
        word[0] = pol;
        write_register(CFG_POLICY, word);
        write_register(CFG_LIMIT, lim);
    endtask

    // Random traffic: most lookups aim at stored keys, most inserts are
    // fresh keys, some are duplicates or near misses of stored keys.
    task automatic run_random(int unsigned count);
        t_tlb_key key;
        logic     cmd;
        for (int unsigned k = 0; k < count; k++) begin
            cmd = ($urandom_range(0, 99) < 40) ? CMD_INSERT : CMD_LOOKUP;
            key = {PID_W'($urandom), PAGE_BITS'($urandom)};
            if (key_pool.size() > 0) begin
                if ((cmd == CMD_LOOKUP && $urandom_range(0, 99) < 70) ||
                    (cmd == CMD_INSERT && $urandom_range(0, 99) < 15)) begin
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end else if ($urandom_range(0, 99) < 20) begin
                    // Near miss: one half of a stored key kept.
                    if ($urandom_range(0, 1) == 1) begin
                        key.pid = key_pool[$urandom_range(0, key_pool.size() - 1)].pid;
                    end else begin
                        key.page = key_pool[$urandom_range(0, key_pool.size() - 1)].page;
                    end
                end
            end
            if (cmd == CMD_INSERT) begin
                key_pool.push_back(key);
                if (key_pool.size() > 40) begin
                    void'(key_pool.pop_front());
                end
            end
            send_request(cmd, key.pid, key.page, FRAME_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random readiness, with one long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned r;
        int unsigned run;
        m_tready = 1'b0;
        forever begin
            if (hold_results) begin
                m_tready = 1'b0;
                repeat (600) @(negedge clk);
                hold_results = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    m_tready = 1'b1;
                    run = $urandom_range(1, 8);
                end else if (r < 80) begin
                    m_tready = 1'b0;
                    run = $urandom_range(1, 4);
                end else if (r < 90) begin
                    m_tready = 1'b1;
                    run = $urandom_range(50, 200);
                end else begin
                    m_tready = 1'b0;
                    run = $urandom_range(20, 80);
                end
                repeat (run) @(negedge clk);
            end
        end
    end

    // Every accepted result transfer is checked against the mirror.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            mirror.check_result(m_tuser, m_tdata[FRAME_W-1:0],
                                m_tdata[FRAME_W+SLOT_W-1:FRAME_W]);
        end
    end

    // Watchdog against a hung handshake.
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic        pol_plan[6];
        int unsigned lim_plan[6];
        pol_plan = '{POL_LRU, POL_FIFO, POL_LRU, POL_FIFO, POL_LRU, POL_FIFO};
        lim_plan = '{0, 9, 20, 63, 32, 1};

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = CMD_LOOKUP;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POLICY;
        cfg_data  = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // FIFO with three entries: empty lookup, extremes, near misses,
        // then replacement by birth order.
        configure(POL_FIFO, 3);
        send_request(CMD_LOOKUP, '0, '0, '0);
        send_request(CMD_INSERT, '0, '0, '0);
        send_request(CMD_INSERT, '1, '1, '1);
        send_request(CMD_INSERT, '0, '1, 20'h5A5A5);
        send_request(CMD_LOOKUP, '0, '0, '1);
        send_request(CMD_LOOKUP, '1, '1, '0);
        send_request(CMD_LOOKUP, '1, '0, '0);
        send_request(CMD_LOOKUP, 32'h8000_0000, 20'h80000, '0);
        send_request(CMD_INSERT, '0, '0, 20'hA5A5A);
        send_request(CMD_INSERT, 32'h1234_5678, 20'h0F0F0, 20'h3C3C3);
        send_request(CMD_LOOKUP, '0, '0, '0);
        send_request(CMD_LOOKUP, '1, '1, '0);

        // LRU with six entries: duplicate keys while filling, hits that
        // refresh the use time, then replacement by least recent use.
        configure(POL_LRU, 6);
        send_request(CMD_INSERT, 32'd7, 20'd7, 20'd1);
        send_request(CMD_INSERT, 32'd7, 20'd7, 20'd2);
        send_request(CMD_INSERT, 32'd9, 20'd9, 20'd3);
        send_request(CMD_LOOKUP, 32'd7, 20'd7, '0);
        send_request(CMD_LOOKUP, '0, 20'h0F0F0, '0);
        send_request(CMD_LOOKUP, 32'h1234_5678, 20'h0F0F0, '0);
        send_request(CMD_LOOKUP, '0, '0, '0);
        send_request(CMD_INSERT, 32'd11, 20'd11, 20'd4);
        send_request(CMD_INSERT, 32'd12, 20'd12, 20'd5);
        send_request(CMD_LOOKUP, 32'd7, 20'd7, '0);
        send_request(CMD_LOOKUP, 32'd9, 20'd9, '0);

        // Random phases over the policies and limits, extremes included.
        for (int p = 0; p < 6; p++) begin
            configure(pol_plan[p], CFG_DATA_W'(lim_plan[p]));
            if (p == 2) begin
                hold_results = 1'b1;
            end
            run_random(175);
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        wait_quiet();
        if (mirror.outstanding() != 0) begin
            $error("%0d results never arrived", mirror.outstanding());
            mirror.errors++;
        end
        if (mirror.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/tlb_pkg.sv
src/tlb_cell.sv
src/tlb_chain.sv
src/tlb_fifo_lru_replacement.sv
src/tlb_chk.sv
tb/tb_tlb_fifo_lru_replacement.sv
